// File: design/smartcard_atr_parser_unit_assert.svh
// Assertion macros used by the answer-to-reset parser unit.
`ifndef SMARTCARD_ATR_PARSER_UNIT_ASSERT_SVH
`define SMARTCARD_ATR_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SATR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("satr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SATR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("satr assertion failed");

`endif

// File: design/satr_pkg.sv
package satr_pkg;

   localparam int MAX_ATR_BYTES_DEFAULT = 32;

   localparam int POS_W    = 6;
   localparam int GLEFT_W  = 3;
   localparam int NIB_W    = 4;
   localparam int IFACE_W  = 5;
   localparam int KIND_W   = 3;

   localparam logic [POS_W-1:0]   POS_SAT   = 6'd63;
   localparam logic [IFACE_W-1:0] IFACE_SAT = 5'd31;
   localparam logic [NIB_W-1:0]   GROUP_SAT = 4'd15;

   typedef enum logic [KIND_W-1:0] {
      KIND_TS    = 3'd0,
      KIND_T0    = 3'd1,
      KIND_IFACE = 3'd2,
      KIND_HIST  = 3'd3,
      KIND_EXTRA = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type             byte_kind;
      logic [IFACE_W-1:0]   item_index;
      logic [NIB_W-1:0]     protocol;
      logic [NIB_W-1:0]     historical_total;
      logic [IFACE_W-1:0]   interface_total;
      logic                 complete;
      logic                 overflow;
   } result_type;

   function automatic logic [GLEFT_W-1:0] ones_in_nibble(input logic [NIB_W-1:0] n);
      return GLEFT_W'(n[0]) + GLEFT_W'(n[1]) + GLEFT_W'(n[2]) + GLEFT_W'(n[3]);
   endfunction

endpackage

// File: design/satr_parse.sv
module satr_parse #(
   parameter int MAX_ATR_BYTES = satr_pkg::MAX_ATR_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           atr_byte,
   input  logic                 restart,
   output satr_pkg::result_type result
);

   logic [satr_pkg::POS_W-1:0]   pos_ff,   pos_in;
   logic [satr_pkg::GLEFT_W-1:0] gleft_ff, gleft_in;
   logic                         td_ff,    td_in;
   logic [satr_pkg::NIB_W-1:0]   hcnt_ff,  hcnt_in;
   logic [satr_pkg::NIB_W-1:0]   hseen_ff, hseen_in;
   logic [satr_pkg::IFACE_W-1:0] iface_ff, iface_in;
   logic [satr_pkg::NIB_W-1:0]   group_ff, group_in;
   logic [satr_pkg::NIB_W-1:0]   proto_ff, proto_in;

   always_comb begin
      logic [satr_pkg::POS_W-1:0]   pos;
      logic [satr_pkg::GLEFT_W-1:0] gl_dec;
      pos      = restart ? '0 : pos_ff;
      gleft_in = restart ? '0 : gleft_ff;
      td_in    = restart ? 1'b0 : td_ff;
      hcnt_in  = restart ? '0 : hcnt_ff;
      hseen_in = restart ? '0 : hseen_ff;
      iface_in = restart ? '0 : iface_ff;
      group_in = restart ? '0 : group_ff;
      proto_in = restart ? '0 : proto_ff;
      gl_dec   = gleft_in - 3'd1;
      result.byte_kind  = satr_pkg::KIND_EXTRA;
      result.item_index = '0;
      result.complete   = 1'b0;
      result.overflow   = 1'b0;

      priority if (pos == '0) begin
         result.byte_kind = satr_pkg::KIND_TS;
      end else if ({1'b0, pos} >= 7'(MAX_ATR_BYTES) || pos == satr_pkg::POS_SAT) begin
         result.overflow = 1'b1;
      end else if (pos == 6'd1) begin
         result.byte_kind = satr_pkg::KIND_T0;
         hcnt_in  = atr_byte[3:0];
         hseen_in = '0;
         iface_in = '0;
         group_in = 4'd1;
         gleft_in = satr_pkg::ones_in_nibble(atr_byte[7:4]);
         td_in    = atr_byte[7];
         result.complete = (gleft_in == '0) && (atr_byte[3:0] == '0);
      end else if (gleft_in != '0) begin
         result.byte_kind  = satr_pkg::KIND_IFACE;
         result.item_index = iface_in;
         if (iface_in < satr_pkg::IFACE_SAT) begin
            iface_in = iface_in + 5'd1;
         end
         if (gl_dec == '0 && td_in) begin
            if (group_in == 4'd1) begin
               proto_in = atr_byte[3:0];
            end
            if (group_in < satr_pkg::GROUP_SAT) begin
               group_in = group_in + 4'd1;
            end
            gleft_in = satr_pkg::ones_in_nibble(atr_byte[7:4]);
            td_in    = atr_byte[7];
         end else begin
            gleft_in = gl_dec;
         end
         result.complete = (gleft_in == '0) && (hseen_in >= hcnt_in);
      end else if (hseen_in < hcnt_in) begin
         result.byte_kind  = satr_pkg::KIND_HIST;
         result.item_index = satr_pkg::IFACE_W'(hseen_in);
         hseen_in = hseen_in + 4'd1;
         result.complete = (hseen_in >= hcnt_in);
      end else begin
         result.byte_kind = satr_pkg::KIND_EXTRA;
      end

      pos_in = (pos < satr_pkg::POS_SAT) ? pos + 6'd1 : pos;
      result.protocol         = proto_in;
      result.historical_total = hcnt_in;
      result.interface_total  = iface_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         gleft_ff <= '0;
         td_ff    <= 1'b0;
         hcnt_ff  <= '0;
         hseen_ff <= '0;
         iface_ff <= '0;
         group_ff <= '0;
         proto_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         gleft_ff <= gleft_in;
         td_ff    <= td_in;
         hcnt_ff  <= hcnt_in;
         hseen_ff <= hseen_in;
         iface_ff <= iface_in;
         group_ff <= group_in;
         proto_ff <= proto_in;
      end
   end

endmodule

// File: design/smartcard_atr_parser_unit.sv
// Answer-to-reset byte classifier for an ISO 7816 card interface.
// The request channel (req_valid, req_stall, req_atr_byte, req_restart) takes one
// received byte per request; req_restart marks TS, the first byte of a new answer.
// The response channel (rsp_valid, rsp_stall, rsp_*) returns one result per request:
// the byte kind, its index, the protocol from TD1, the announced historical count,
// the interface byte count, and the complete and overflow flags.
// A request is accepted into an input register, then classified against the parse state
// and written to the response register once that register is empty or its response is
// taken. One request is accepted in every cycle while req_stall is low.
// The parse state advances only when a request moves into the response register.
// When the receiver stalls, the response register holds its contents and the input
// register can still take one more request; after that req_stall rises until the
// response is taken. Synchronous reset clears the valid flags of both registers and
// the parse state, and the next byte after reset is taken as TS.
`include "smartcard_atr_parser_unit_assert.svh"

module smartcard_atr_parser_unit #(
   parameter int MAX_ATR_BYTES = satr_pkg::MAX_ATR_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_atr_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_byte_kind,
   output logic [4:0] rsp_item_index,
   output logic [3:0] rsp_protocol,
   output logic [3:0] rsp_historical_total,
   output logic [4:0] rsp_interface_total,
   output logic       rsp_complete,
   output logic       rsp_overflow
);

   logic                 in_vld_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_restart_ff;
   logic                 out_vld_ff;
   satr_pkg::result_type out_ff;
   satr_pkg::result_type result;
   logic                 advance;
   logic                 req_take;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && out_vld_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   satr_parse #(
      .MAX_ATR_BYTES(MAX_ATR_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .atr_byte (in_byte_ff),
      .restart  (in_restart_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff    <= req_atr_byte;
         in_restart_ff <= req_restart;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_byte_kind        = out_ff.byte_kind;
   assign rsp_item_index       = out_ff.item_index;
   assign rsp_protocol         = out_ff.protocol;
   assign rsp_historical_total = out_ff.historical_total;
   assign rsp_interface_total  = out_ff.interface_total;
   assign rsp_complete         = out_ff.complete;
   assign rsp_overflow         = out_ff.overflow;

   `SATR_ASSERT_NOW(a_ovf_is_extra, clock, reset, rsp_valid && rsp_overflow,
      rsp_byte_kind == satr_pkg::KIND_EXTRA && !rsp_complete)
   `SATR_ASSERT_NOW(a_ts_clean, clock, reset,
      rsp_valid && rsp_byte_kind == satr_pkg::KIND_TS,
      rsp_item_index == '0 && rsp_interface_total == '0 && rsp_protocol == '0)
   `SATR_ASSERT_NOW(a_stall_full, clock, reset, req_stall, in_vld_ff && out_vld_ff)
   `SATR_ASSERT_NEXT(a_hold_rsp, clock, reset, out_vld_ff && rsp_stall,
      out_vld_ff && $stable(out_ff))

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import satr_pkg::*;

   localparam int MAX_BYTES = MAX_ATR_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 235;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER = 520;

   class atr_scoreboard;
      result_type expected_results[$];
      int errors;
      int requests;
      int kind_seen[5];
      int overflow_seen;
      int complete_seen;

      logic [POS_W-1:0]   position;
      logic [GLEFT_W-1:0] group_left;
      logic               td_pending;
      logic [NIB_W-1:0]   hist_total;
      logic [NIB_W-1:0]   hist_seen;
      logic [IFACE_W-1:0] iface_total;
      logic [NIB_W-1:0]   group_num;
      logic [NIB_W-1:0]   proto;

      function new();
         errors = 0;
         requests = 0;
         overflow_seen = 0;
         complete_seen = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         position = '0;
         group_left = '0;
         td_pending = 1'b0;
         hist_total = '0;
         hist_seen = '0;
         iface_total = '0;
         group_num = '0;
         proto = '0;
      endfunction

      function void open_group(logic [7:0] b);
         group_left = GLEFT_W'($countones(b[7:4]));
         td_pending = b[7];
      endfunction

      function logic answer_done();
         return (group_left == '0) && (hist_seen >= hist_total);
      endfunction

      function result_type classify_byte(logic [7:0] b, logic restart);
         result_type r;
         r.byte_kind = KIND_EXTRA;
         r.item_index = '0;
         r.complete = 1'b0;
         r.overflow = 1'b0;
         if (restart) clear_parse();
         if (position == '0) begin
            r.byte_kind = KIND_TS;
         end else if (int'(position) >= MAX_BYTES || position >= POS_SAT) begin
            r.overflow = 1'b1;
         end else if (position == POS_W'(1)) begin
            r.byte_kind = KIND_T0;
            hist_total = b[3:0];
            hist_seen = '0;
            iface_total = '0;
            group_num = NIB_W'(1);
            open_group(b);
            r.complete = answer_done();
         end else if (group_left != '0) begin
            r.byte_kind = KIND_IFACE;
            r.item_index = iface_total;
            if (iface_total < IFACE_SAT) iface_total++;
            group_left--;
            if (group_left == '0 && td_pending) begin
               if (group_num == NIB_W'(1)) proto = b[3:0];
               if (group_num < GROUP_SAT) group_num++;
               open_group(b);
            end
            r.complete = answer_done();
         end else if (hist_seen < hist_total) begin
            r.byte_kind = KIND_HIST;
            r.item_index = IFACE_W'(hist_seen);
            hist_seen++;
            r.complete = answer_done();
         end
         if (position < POS_SAT) position++;
         r.protocol = proto;
         r.historical_total = hist_total;
         r.interface_total = iface_total;
         return r;
      endfunction

      function void note_request(logic [7:0] b, logic restart);
         expected_results.push_back(classify_byte(b, restart));
         requests++;
      endfunction

      function void compare_field(string name, int expv, int actv);
         if (expv != actv) begin
            $error("%s expected %0d actual %0d", name, expv, actv);
            errors++;
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("byte_kind", want.byte_kind, got.byte_kind);
         compare_field("item_index", want.item_index, got.item_index);
         compare_field("protocol", want.protocol, got.protocol);
         compare_field("historical_total", want.historical_total, got.historical_total);
         compare_field("interface_total", want.interface_total, got.interface_total);
         compare_field("complete", want.complete, got.complete);
         compare_field("overflow", want.overflow, got.overflow);
         if (int'(got.byte_kind) < 5) kind_seen[got.byte_kind]++;
         if (got.overflow) overflow_seen++;
         if (got.complete) complete_seen++;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_atr_byte = 8'h00;
   logic       req_restart = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_byte_kind;
   logic [4:0] rsp_item_index;
   logic [3:0] rsp_protocol;
   logic [3:0] rsp_historical_total;
   logic [4:0] rsp_interface_total;
   logic       rsp_complete;
   logic       rsp_overflow;

   atr_scoreboard board;
   int send_idle_pct = 38;
   int recv_idle_pct = 77;
   int answers_sent = 0;
   int cycle_count = 0;

   smartcard_atr_parser_unit #(.MAX_ATR_BYTES(MAX_BYTES)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_atr_byte(req_atr_byte),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_byte_kind(rsp_byte_kind),
      .rsp_item_index(rsp_item_index),
      .rsp_protocol(rsp_protocol),
      .rsp_historical_total(rsp_historical_total),
      .rsp_interface_total(rsp_interface_total),
      .rsp_complete(rsp_complete),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver stalls at random and, once, holds off long enough to back up the input.
   initial begin : receiver
      int taken;
      int hold_left;
      result_type got;
      taken = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.byte_kind = kind_type'(rsp_byte_kind);
            got.item_index = rsp_item_index;
            got.protocol = rsp_protocol;
            got.historical_total = rsp_historical_total;
            got.interface_total = rsp_interface_total;
            got.complete = rsp_complete;
            got.overflow = rsp_overflow;
            board.check_response(got);
            taken++;
            if (taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[smartcard_atr_parser_unit] ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_atr_byte <= b;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      board.note_request(b, restart);
   endtask

   // Builds a well-formed answer with random content, sometimes cut short or padded.
   task automatic send_answer();
      logic [7:0] seq[$];
      logic [3:0] y;
      logic [3:0] ny;
      logic       long_one;
      logic       first_restart;
      int nbytes;
      int groups;
      int keep;
      int i;
      long_one = ($urandom_range(7) == 0);
      seq.push_back(($urandom_range(3) == 0) ? 8'($urandom) :
                    ($urandom_range(1) ? 8'h3B : 8'h3F));
      y = long_one ? 4'hF : 4'($urandom);
      seq.push_back({y, long_one ? 4'hF : 4'($urandom)});
      groups = 0;
      while (y != 4'h0) begin
         nbytes = $countones(y);
         ny = 4'h0;
         for (i = 0; i < nbytes; i++) begin
            if (i == nbytes - 1 && y[3]) begin
               ny = long_one ? 4'hF : 4'($urandom);
               if (groups >= 8) ny[3] = 1'b0;
               seq.push_back({ny, 4'($urandom)});
            end else begin
               seq.push_back(8'($urandom));
            end
         end
         groups++;
         y = ny;
      end
      for (i = 0; i < int'(seq[1][3:0]); i++) seq.push_back(8'($urandom));
      if ($urandom_range(3) == 0) begin
         nbytes = $urandom_range(1, 3);
         for (i = 0; i < nbytes; i++) seq.push_back(8'($urandom));
      end
      keep = seq.size();
      if ($urandom_range(7) == 0) keep = $urandom_range(1, seq.size());
      first_restart = ($urandom_range(9) != 0);
      for (i = 0; i < keep; i++) send_byte(seq[i], (i == 0) ? first_restart : 1'b0);
      answers_sent++;
   endtask

   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_byte(8'($urandom), ($urandom_range(7) == 0));
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct);
      int start;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      start = board.requests;
      while (board.requests - start < PHASE_ITEMS) begin
         if ($urandom_range(99) < 85) send_answer();
         else send_noise();
      end
   endtask

   initial begin : stimulus
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A first byte without restart is still TS; an empty T0 completes at once.
      send_byte(8'h3B, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // Full first group, TD1 selects protocol 1, TD2 ends the chain, then two
      // historical bytes and one byte past the answer.
      send_byte(8'h3F, 1'b1);
      send_byte(8'hF2, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h00, 1'b0);
      // A restart in the middle of an answer clears the parse.
      send_byte(8'h3B, 1'b1);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h8E, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h01, 1'b0);

      run_phase(38, 77);
      run_phase(77, 38);
      run_phase(0, 0);
      req_valid <= 1'b0;

      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d requests in %0d generated answers over %0d cycles.",
               board.requests, answers_sent, cycle_count);
      $display("Kinds TS/T0/iface/hist/extra: %0d/%0d/%0d/%0d/%0d, overflow %0d, complete %0d.",
               board.kind_seen[0], board.kind_seen[1], board.kind_seen[2],
               board.kind_seen[3], board.kind_seen[4], board.overflow_seen,
               board.complete_seen);
      if (board.errors == 0) begin
         $display("[smartcard_atr_parser_unit] OK");
      end else begin
         $display("[smartcard_atr_parser_unit] ERROR");
      end
      $finish;
   end
endmodule
